// ===== design/fma_pkg.sv =====
package fma_pkg;

  localparam logic [31:0] QNAN_BITS = 32'h7fc0_0000;
  localparam logic [31:0] INF_BITS  = 32'h7f80_0000;
  localparam logic [31:0] MAX_BITS  = 32'h7f7f_ffff;
  localparam logic [31:0] SIGN_BIT  = 32'h8000_0000;
  localparam logic [23:0] HIDDEN    = 24'h80_0000;
  localparam int unsigned LATENCY   = 6;

  typedef logic [1:0] rmode_t;
  localparam rmode_t RM_NEAREST = 2'd0;
  localparam rmode_t RM_UP      = 2'd1;
  localparam rmode_t RM_DOWN    = 2'd2;
  localparam rmode_t RM_ZERO    = 2'd3;

  typedef logic signed [11:0] exp_t;

  typedef struct packed {
    logic        valid;
    logic        spec;
    logic [31:0] spec_res;
    rmode_t      mode;
    logic        sp;
    logic        sc;
    logic        zc;
    logic [47:0] prod;
    exp_t        eab;
    logic [23:0] mc;
    exp_t        ec;
  } unp_t;

  typedef struct packed {
    logic        valid;
    logic        spec;
    logic [31:0] spec_res;
    rmode_t      mode;
    logic        sp;
    logic        sc;
    logic        zc;
    logic [47:0] prod;
    exp_t        eab;
    logic [23:0] mc;
    exp_t        ec;
    logic [6:0]  clzp;
    logic [6:0]  clzc;
  } lzc_t;

  typedef struct packed {
    logic        valid;
    logic        spec;
    logic [31:0] spec_res;
    rmode_t      mode;
    logic        sign;
    logic        sub;
    logic [63:0] big;
    logic [63:0] small_v;
    exp_t        ebig;
    logic [6:0]  d;
  } swap_t;

  typedef struct packed {
    logic        valid;
    logic        spec;
    logic [31:0] spec_res;
    rmode_t      mode;
    logic        sign;
    exp_t        ebig;
    logic [63:0] r;
    logic        lost;
  } sum_t;

  function automatic logic [6:0] lead_zeros64(input logic [63:0] v);
    logic [6:0] n;
    n = 7'd64;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) begin
        n = 7'(63 - i);
      end
    end
    return n;
  endfunction

  function automatic exp_t exp_of(input logic [7:0] x);
    exp_t e;
    e = (x == 8'd0) ? 12'sd1 : exp_t'({4'b0, x});
    return e - 12'sd150;
  endfunction

endpackage

// ===== design/fma_unpack.sv =====
module fma_unpack (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  fma_pkg::rmode_t     mode,
  input  logic [31:0]         a,
  input  logic [31:0]         b,
  input  logic [31:0]         c,
  output fma_pkg::unp_t       stage_r
);

  fma_pkg::unp_t stage_nxt;
  logic [7:0]  xa, xb, xc;
  logic [22:0] fa, fb, fc;
  logic        za, zb, zc, sp;
  logic [23:0] ma, mb;

  always_comb begin
    xa = a[30:23];
    xb = b[30:23];
    xc = c[30:23];
    fa = a[22:0];
    fb = b[22:0];
    fc = c[22:0];
    za = (xa == 8'd0) && (fa == 23'd0);
    zb = (xb == 8'd0) && (fb == 23'd0);
    zc = (xc == 8'd0) && (fc == 23'd0);
    sp = a[31] ^ b[31];
    ma = {xa != 8'd0, fa};
    mb = {xb != 8'd0, fb};

    stage_nxt.valid    = accept;
    stage_nxt.spec     = 1'b1;
    stage_nxt.spec_res = fma_pkg::QNAN_BITS;
    if ((xa == 8'hff && fa != 23'd0) || (xb == 8'hff && fb != 23'd0) ||
        (xc == 8'hff && fc != 23'd0)) begin
      stage_nxt.spec_res = fma_pkg::QNAN_BITS;
    end else if (xa == 8'hff || xb == 8'hff) begin
      if (za || zb || (xc == 8'hff && c[31] != sp)) begin
        stage_nxt.spec_res = fma_pkg::QNAN_BITS;
      end else begin
        stage_nxt.spec_res = fma_pkg::INF_BITS | {sp, 31'd0};
      end
    end else if (xc == 8'hff) begin
      stage_nxt.spec_res = c;
    end else if (za || zb) begin
      if (!zc) begin
        stage_nxt.spec_res = c;
      end else if (sp == c[31]) begin
        stage_nxt.spec_res = {sp, 31'd0};
      end else begin
        stage_nxt.spec_res = (mode == fma_pkg::RM_DOWN) ? fma_pkg::SIGN_BIT : 32'd0;
      end
    end else begin
      stage_nxt.spec = 1'b0;
    end
    stage_nxt.mode = mode;
    stage_nxt.sp   = sp;
    stage_nxt.sc   = c[31];
    stage_nxt.zc   = zc;
    stage_nxt.prod = ma * mb;
    stage_nxt.eab  = fma_pkg::exp_of(xa) + fma_pkg::exp_of(xb);
    stage_nxt.mc   = {xc != 8'd0, fc};
    stage_nxt.ec   = fma_pkg::exp_of(xc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else begin
      stage_r.valid <= stage_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    stage_r.spec     <= stage_nxt.spec;
    stage_r.spec_res <= stage_nxt.spec_res;
    stage_r.mode     <= stage_nxt.mode;
    stage_r.sp       <= stage_nxt.sp;
    stage_r.sc       <= stage_nxt.sc;
    stage_r.zc       <= stage_nxt.zc;
    stage_r.prod     <= stage_nxt.prod;
    stage_r.eab      <= stage_nxt.eab;
    stage_r.mc       <= stage_nxt.mc;
    stage_r.ec       <= stage_nxt.ec;
  end

endmodule

// ===== design/fma_align.sv =====
module fma_align (
  input  logic          clk,
  input  logic          rst_n,
  input  fma_pkg::unp_t in_stage,
  output fma_pkg::sum_t stage_r
);

  fma_pkg::lzc_t  lz_r, lz_nxt;
  fma_pkg::swap_t sw_r, sw_nxt;
  fma_pkg::sum_t  stage_nxt;

  logic [63:0]   mp, mcn, st, mask;
  fma_pkg::exp_t ep, ec, diff;
  logic          p_big;

  always_comb begin
    lz_nxt      = '0;
    lz_nxt.valid    = in_stage.valid;
    lz_nxt.spec     = in_stage.spec;
    lz_nxt.spec_res = in_stage.spec_res;
    lz_nxt.mode     = in_stage.mode;
    lz_nxt.sp       = in_stage.sp;
    lz_nxt.sc       = in_stage.sc;
    lz_nxt.zc       = in_stage.zc;
    lz_nxt.prod     = in_stage.prod;
    lz_nxt.eab      = in_stage.eab;
    lz_nxt.mc       = in_stage.mc;
    lz_nxt.ec       = in_stage.ec;
    lz_nxt.clzp     = fma_pkg::lead_zeros64({16'd0, in_stage.prod});
    lz_nxt.clzc     = fma_pkg::lead_zeros64({40'd0, in_stage.mc});
  end

  always_comb begin
    mp  = {16'd0, lz_r.prod} << 7'(lz_r.clzp - 7'd1);
    mcn = {40'd0, lz_r.mc} << 7'(lz_r.clzc - 7'd1);
    ep  = lz_r.eab - fma_pkg::exp_t'({5'd0, lz_r.clzp}) + 12'sd1;
    ec  = lz_r.ec - fma_pkg::exp_t'({5'd0, lz_r.clzc}) + 12'sd1;
    p_big = (ep > ec) || ((ep == ec) && (mp > mcn));

    sw_nxt.valid    = lz_r.valid;
    sw_nxt.spec     = lz_r.spec;
    sw_nxt.spec_res = lz_r.spec_res;
    sw_nxt.mode     = lz_r.mode;
    diff = 12'sd0;
    if (lz_r.zc) begin
      sw_nxt.big     = mp;
      sw_nxt.small_v = 64'd0;
      sw_nxt.ebig    = ep;
      sw_nxt.sign    = lz_r.sp;
      sw_nxt.sub     = 1'b0;
    end else if (p_big) begin
      sw_nxt.big     = mp;
      sw_nxt.small_v = mcn;
      sw_nxt.ebig    = ep;
      sw_nxt.sign    = lz_r.sp;
      sw_nxt.sub     = lz_r.sp != lz_r.sc;
      diff           = ep - ec;
    end else begin
      sw_nxt.big     = mcn;
      sw_nxt.small_v = mp;
      sw_nxt.ebig    = ec;
      sw_nxt.sign    = lz_r.sc;
      sw_nxt.sub     = lz_r.sp != lz_r.sc;
      diff           = ec - ep;
    end
    sw_nxt.d = (diff >= 12'sd64) ? 7'd64 : diff[6:0];
  end

  always_comb begin
    mask = (64'd1 << sw_r.d[5:0]) - 64'd1;
    stage_nxt.valid    = sw_r.valid;
    stage_nxt.mode     = sw_r.mode;
    stage_nxt.sign     = sw_r.sign;
    stage_nxt.ebig     = sw_r.ebig;
    if (sw_r.d[6]) begin
      st             = 64'd0;
      stage_nxt.lost = 1'b1;
    end else begin
      st             = sw_r.small_v >> sw_r.d[5:0];
      stage_nxt.lost = (sw_r.small_v & mask) != 64'd0;
    end
    if (sw_r.sub) begin
      stage_nxt.r = sw_r.big - st - {63'd0, stage_nxt.lost};
    end else begin
      stage_nxt.r = sw_r.big + st;
    end
    stage_nxt.spec     = sw_r.spec;
    stage_nxt.spec_res = sw_r.spec_res;
    if (!sw_r.spec && sw_r.sub && stage_nxt.r == 64'd0) begin
      stage_nxt.spec     = 1'b1;
      stage_nxt.spec_res = (sw_r.mode == fma_pkg::RM_DOWN) ? fma_pkg::SIGN_BIT : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lz_r.valid    <= 1'b0;
      sw_r.valid    <= 1'b0;
      stage_r.valid <= 1'b0;
    end else begin
      lz_r.valid    <= lz_nxt.valid;
      sw_r.valid    <= sw_nxt.valid;
      stage_r.valid <= stage_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    lz_r.spec     <= lz_nxt.spec;
    lz_r.spec_res <= lz_nxt.spec_res;
    lz_r.mode     <= lz_nxt.mode;
    lz_r.sp       <= lz_nxt.sp;
    lz_r.sc       <= lz_nxt.sc;
    lz_r.zc       <= lz_nxt.zc;
    lz_r.prod     <= lz_nxt.prod;
    lz_r.eab      <= lz_nxt.eab;
    lz_r.mc       <= lz_nxt.mc;
    lz_r.ec       <= lz_nxt.ec;
    lz_r.clzp     <= lz_nxt.clzp;
    lz_r.clzc     <= lz_nxt.clzc;
    sw_r.spec     <= sw_nxt.spec;
    sw_r.spec_res <= sw_nxt.spec_res;
    sw_r.mode     <= sw_nxt.mode;
    sw_r.sign     <= sw_nxt.sign;
    sw_r.sub      <= sw_nxt.sub;
    sw_r.big      <= sw_nxt.big;
    sw_r.small_v  <= sw_nxt.small_v;
    sw_r.ebig     <= sw_nxt.ebig;
    sw_r.d        <= sw_nxt.d;
    stage_r.spec     <= stage_nxt.spec;
    stage_r.spec_res <= stage_nxt.spec_res;
    stage_r.mode     <= stage_nxt.mode;
    stage_r.sign     <= stage_nxt.sign;
    stage_r.ebig     <= stage_nxt.ebig;
    stage_r.r        <= stage_nxt.r;
    stage_r.lost     <= stage_nxt.lost;
  end

endmodule

// ===== design/fma_round.sv =====
module fma_round (
  input  logic          clk,
  input  logic          rst_n,
  input  fma_pkg::sum_t in_stage,
  output logic          valid_r,
  output logic [31:0]   result_r
);

  logic            v5_r, spec5_r, sign5_r, lost5_r;
  logic [31:0]     sres5_r;
  fma_pkg::rmode_t mode5_r;
  logic [63:0]     r5_r;
  fma_pkg::exp_t   q5_r, s5_r, q_nxt, s_nxt, e, p, ns, qf;
  logic [31:0]     mant, result_nxt;
  logic            g, lost, inc;
  logic [5:0]      sh, shm;

  always_comb begin
    p     = fma_pkg::exp_t'({5'd0, 7'(7'd63 - fma_pkg::lead_zeros64(in_stage.r))});
    e     = in_stage.ebig + p;
    q_nxt = (e >= -12'sd126) ? e - 12'sd23 : -12'sd149;
    s_nxt = q_nxt - in_stage.ebig;
  end

  always_comb begin
    ns   = -s5_r;
    sh   = s5_r[5:0];
    shm  = 6'(sh - 6'd1);
    lost = lost5_r;
    g    = 1'b0;
    mant = 32'd0;
    if (s5_r <= 12'sd0) begin
      mant = (ns >= 12'sd32) ? 32'd0 : 32'(r5_r << ns[4:0]);
    end else if (s5_r <= 12'sd63) begin
      mant = 32'(r5_r >> sh);
      g    = r5_r[shm];
      lost = lost5_r || ((r5_r & ((64'd1 << shm) - 64'd1)) != 64'd0);
    end else if (s5_r == 12'sd64) begin
      g    = r5_r[63];
      lost = lost5_r || (r5_r[62:0] != 63'd0);
    end else begin
      lost = 1'b1;
    end
    case (mode5_r)
      fma_pkg::RM_NEAREST: inc = g && (lost || mant[0]);
      fma_pkg::RM_UP:      inc = (g || lost) && !sign5_r;
      fma_pkg::RM_DOWN:    inc = (g || lost) && sign5_r;
      default:             inc = 1'b0;
    endcase
    mant = mant + {31'd0, inc};
    qf   = q5_r;
    if (mant[24]) begin
      mant = mant >> 1;
      qf   = q5_r + 12'sd1;
    end
    if (spec5_r) begin
      result_nxt = sres5_r;
    end else if (mant[23] && qf >= 12'sd105) begin
      case (mode5_r)
        fma_pkg::RM_NEAREST: result_nxt = fma_pkg::INF_BITS | {sign5_r, 31'd0};
        fma_pkg::RM_UP:      result_nxt = sign5_r ? (fma_pkg::MAX_BITS | fma_pkg::SIGN_BIT)
                                                  : fma_pkg::INF_BITS;
        fma_pkg::RM_DOWN:    result_nxt = sign5_r ? (fma_pkg::INF_BITS | fma_pkg::SIGN_BIT)
                                                  : fma_pkg::MAX_BITS;
        default:             result_nxt = fma_pkg::MAX_BITS | {sign5_r, 31'd0};
      endcase
    end else if (!mant[23]) begin
      result_nxt = mant | {sign5_r, 31'd0};
    end else begin
      result_nxt = ({20'(qf + 12'sd149), 12'd0} << 11) + mant + {sign5_r, 31'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r    <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      v5_r    <= in_stage.valid;
      valid_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    spec5_r  <= in_stage.spec;
    sres5_r  <= in_stage.spec_res;
    mode5_r  <= in_stage.mode;
    sign5_r  <= in_stage.sign;
    lost5_r  <= in_stage.lost;
    r5_r     <= in_stage.r;
    q5_r     <= q_nxt;
    s5_r     <= s_nxt;
    result_r <= result_nxt;
  end

endmodule

// ===== design/fused_multiply_add_f32.sv =====
// Channel  | Handshake             | Payload
// input    | start, busy           | in_multiplicand_bits, in_multiplier_bits, in_addend_bits
// result   | out_valid (strobe)    | out_result_bits
// config   | psel, penable, pwrite | paddr, pwdata, prdata, pready
//
// An item is taken in every cycle; its result leaves the last of the register stages below
// together with the result strobe out_valid.
// The six register stages are unpack and multiply, leading-zero count, swap, align and add,
// normalise, and round; the 24 by 24 multiplier sets the first stage.
// Reset is synchronous and clears the valid bits and the rounding mode.
// The receiver cannot stall, so busy stays low and nothing is held back.
module fused_multiply_add_f32 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_multiplicand_bits,
  input  logic [31:0] in_multiplier_bits,
  input  logic [31:0] in_addend_bits,
  output logic        out_valid,
  output logic [31:0] out_result_bits,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  fma_pkg::rmode_t mode_r;
  fma_pkg::unp_t   unp;
  fma_pkg::sum_t   sum;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {30'd0, mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= fma_pkg::RM_NEAREST;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      mode_r <= pwdata[1:0];
    end
  end

  fma_unpack u_unpack (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (start && !busy),
    .mode    (mode_r),
    .a       (in_multiplicand_bits),
    .b       (in_multiplier_bits),
    .c       (in_addend_bits),
    .stage_r (unp)
  );

  fma_align u_align (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_stage (unp),
    .stage_r  (sum)
  );

  fma_round u_round (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_stage (sum),
    .valid_r  (out_valid),
    .result_r (out_result_bits)
  );

  a_out_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, fma_pkg::LATENCY))
    else $error("result strobe without a matching input transfer");

  a_nan_addend: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_addend_bits[30:23] == 8'hff && in_addend_bits[22:0] != 23'd0)
      |-> ##6 (out_valid && out_result_bits == fma_pkg::QNAN_BITS))
    else $error("NaN addend did not give the canonical quiet NaN");

  a_nan_canonical: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_bits[30:23] == 8'hff && out_result_bits[22:0] != 23'd0)
      |-> out_result_bits == fma_pkg::QNAN_BITS)
    else $error("non-canonical NaN on the result");

endmodule
